@@ rtl/core/bdsm_pkg.sv @@
// Shared types and constants for the beam DAC statistics monitor.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bdsm_pkg;

   // Fixed field widths.
   localparam int DAC_BITS_DEFAULT = 12;
   localparam int COUNT_BITS       = 32;
   localparam int COORD_OUT_BITS   = 12;
   localparam int RIM_BITS         = 12;
   localparam int KIND_BITS        = 2;

   // Reset value of the rim radius register.
   localparam logic [RIM_BITS-1:0] RIM_RESET = 12'd2047;

   // Item kinds; the fourth code is unused and changes nothing.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_DAC   = 2'd0,
      KIND_BLANK = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE_X,
      ST_SQUARE_Y,
      ST_ROOT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic square_x;
      logic square_y;
      logic root_step;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic lit_write;
   } status_type;

endpackage : bdsm_pkg

`default_nettype wire

@@ rtl/core/bdsm_ctrl.sv @@
// Controller state machine for the beam DAC statistics monitor.
// Depends on bdsm_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bdsm_ctrl #(
   parameter int DAC_BITS = bdsm_pkg::DAC_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bdsm_pkg::status_type status,
   output bdsm_pkg::cmd_type         cmd
);
   import bdsm_pkg::*;

   localparam int CNT_W = $clog2(DAC_BITS);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // State, step counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.lit_write ? ST_SQUARE_X : ST_FINISH;
            end
         end
         ST_SQUARE_X: begin
            cmd.square_x = 1'b1;
            state_in     = ST_SQUARE_Y;
         end
         ST_SQUARE_Y: begin
            cmd.square_y = 1'b1;
            cnt_in       = CNT_W'(DAC_BITS - 1);
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            // Hold here until the result register can take the new statistics.
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // A commit never overwrites a result that has not been transferred.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while result register is occupied");

   // A lit DAC write goes on to the squaring steps.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.lit_write) |=> (state_ff == ST_SQUARE_X))
      else $error("lit write did not start the radius computation");

   // The root loop ends after its last step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && cnt_ff == '0) |=> (state_ff == ST_FINISH))
      else $error("square root loop overran");

   // A result only appears after a commit.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid without commit");

endmodule : bdsm_ctrl

`default_nettype wire

@@ rtl/core/bdsm_datapath.sv @@
// Datapath for the beam DAC statistics monitor: item capture, squaring,
// bit-per-cycle square root, statistics and result registers. Uses bdsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdsm_datapath #(
   parameter int DAC_BITS = bdsm_pkg::DAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bdsm_pkg::cmd_type                     cmd,
   output bdsm_pkg::status_type                       status,
   input  wire logic [bdsm_pkg::KIND_BITS-1:0]        req_kind,
   input  wire logic                                  req_blank_on,
   input  wire logic [DAC_BITS-1:0]                   req_dac_x,
   input  wire logic [DAC_BITS-1:0]                   req_dac_y,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bdsm_pkg::RIM_BITS-1:0]         csr_wr_data,
   output logic [bdsm_pkg::COUNT_BITS-1:0]            rsp_move_count,
   output logic [bdsm_pkg::COUNT_BITS-1:0]            rsp_dot_count,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_low_x,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_high_x,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_low_y,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_high_y,
   output logic [bdsm_pkg::COORD_OUT_BITS-1:0]        rsp_peak_radius,
   output logic [bdsm_pkg::COUNT_BITS-1:0]            rsp_outside_count
);
   import bdsm_pkg::*;

   localparam int N      = DAC_BITS;
   localparam int SQ_W   = 2 * N;
   localparam int REM_W  = N + 2;
   localparam int EXT_W  = (N > COORD_OUT_BITS) ? N : COORD_OUT_BITS;
   localparam int CMP_W  = (N > RIM_BITS) ? N : RIM_BITS;

   localparam logic signed [N-1:0] BOX_LOW_INIT  = {1'b0, {(N-1){1'b1}}};
   localparam logic signed [N-1:0] BOX_HIGH_INIT = {1'b1, {(N-1){1'b0}}};

   // Captured item.
   logic [KIND_BITS-1:0] kind_ff;
   logic                 blank_on_ff;
   logic signed [N-1:0]  cx_ff, cy_ff;

   // Radius computation.
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [N:0]              rem_ff, rem_in;
   logic [N-1:0]            root_ff, root_in;
   logic signed [N-1:0]     mul_op;
   logic signed [SQ_W-1:0]  product;
   logic [REM_W-1:0]        rem_shift, trial;

   // Statistics.
   logic [RIM_BITS-1:0]   rim_ff;
   logic                  blanked_ff, blanked_in;
   logic [COUNT_BITS-1:0] moves_ff, moves_in;
   logic [COUNT_BITS-1:0] dots_ff, dots_in;
   logic [COUNT_BITS-1:0] outside_ff, outside_in;
   logic signed [N-1:0]   min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [N-1:0]   min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [N-1:0]          max_r_ff, max_r_in;

   // Result registers.
   logic [COUNT_BITS-1:0]            rsp_move_ff, rsp_dot_ff, rsp_outside_ff;
   logic signed [COORD_OUT_BITS-1:0] rsp_low_x_ff, rsp_high_x_ff;
   logic signed [COORD_OUT_BITS-1:0] rsp_low_y_ff, rsp_high_y_ff;
   logic [COORD_OUT_BITS-1:0]        rsp_peak_ff;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Low bits of a coordinate after sign extension.
   function automatic logic signed [COORD_OUT_BITS-1:0] coord_out(
      input logic signed [N-1:0] v);
      logic signed [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      return ext[COORD_OUT_BITS-1:0];
   endfunction

   assign status.lit_write = (kind_type'(req_kind) == KIND_DAC) && !blanked_ff;

   // Capture the item; centering on mid-scale flips the code's top bit.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         blank_on_ff <= req_blank_on;
         cx_ff       <= {~req_dac_x[N-1], req_dac_x[N-2:0]};
         cy_ff       <= {~req_dac_y[N-1], req_dac_y[N-2:0]};
      end
   end

   // Shared squarer, then one root bit per step by restoring subtraction.
   always_comb begin
      mul_op    = cmd.square_y ? cy_ff : cx_ff;
      product   = mul_op * mul_op;
      rem_shift = {rem_ff[N-1:0], acc_ff[SQ_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (cmd.square_x) begin
         acc_in = $unsigned(product);
      end else if (cmd.square_y) begin
         acc_in  = acc_ff + $unsigned(product);
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         acc_in = {acc_ff[SQ_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = (N + 1)'(rem_shift - trial);
            root_in = {root_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = (N + 1)'(rem_shift);
            root_in = {root_ff[N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // Statistics after the item held in the capture registers.
   always_comb begin
      blanked_in = blanked_ff;
      moves_in   = moves_ff;
      dots_in    = dots_ff;
      outside_in = outside_ff;
      min_x_in   = min_x_ff;
      max_x_in   = max_x_ff;
      min_y_in   = min_y_ff;
      max_y_in   = max_y_ff;
      max_r_in   = max_r_ff;
      unique case (kind_type'(kind_ff))
         KIND_BLANK: begin
            blanked_in = blank_on_ff;
         end
         KIND_CLEAR: begin
            moves_in   = '0;
            dots_in    = '0;
            outside_in = '0;
            min_x_in   = BOX_LOW_INIT;
            max_x_in   = BOX_HIGH_INIT;
            min_y_in   = BOX_LOW_INIT;
            max_y_in   = BOX_HIGH_INIT;
            max_r_in   = '0;
         end
         KIND_DAC: begin
            if (blanked_ff) begin
               moves_in = sat_inc(moves_ff);
            end else begin
               dots_in = sat_inc(dots_ff);
               if (cx_ff < min_x_ff) min_x_in = cx_ff;
               if (cx_ff > max_x_ff) max_x_in = cx_ff;
               if (cy_ff < min_y_ff) min_y_in = cy_ff;
               if (cy_ff > max_y_ff) max_y_in = cy_ff;
               if (root_ff > max_r_ff) max_r_in = root_ff;
               if (CMP_W'(root_ff) > CMP_W'(rim_ff)) outside_in = sat_inc(outside_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Rim register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         rim_ff <= RIM_RESET;
      end else if (csr_wr_en) begin
         rim_ff <= csr_wr_data;
      end
   end

   // Statistics registers, updated on commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         blanked_ff <= 1'b1;
         moves_ff   <= '0;
         dots_ff    <= '0;
         outside_ff <= '0;
         min_x_ff   <= BOX_LOW_INIT;
         max_x_ff   <= BOX_HIGH_INIT;
         min_y_ff   <= BOX_LOW_INIT;
         max_y_ff   <= BOX_HIGH_INIT;
         max_r_ff   <= '0;
      end else if (cmd.commit) begin
         blanked_ff <= blanked_in;
         moves_ff   <= moves_in;
         dots_ff    <= dots_in;
         outside_ff <= outside_in;
         min_x_ff   <= min_x_in;
         max_x_ff   <= max_x_in;
         min_y_ff   <= min_y_in;
         max_y_ff   <= max_y_in;
         max_r_ff   <= max_r_in;
      end
   end

   // Result registers take the new statistics at the same commit.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_move_ff    <= moves_in;
         rsp_dot_ff     <= dots_in;
         rsp_outside_ff <= outside_in;
         rsp_low_x_ff   <= coord_out(min_x_in);
         rsp_high_x_ff  <= coord_out(max_x_in);
         rsp_low_y_ff   <= coord_out(min_y_in);
         rsp_high_y_ff  <= coord_out(max_y_in);
         rsp_peak_ff    <= COORD_OUT_BITS'(max_r_in);
      end
   end

   assign rsp_move_count    = rsp_move_ff;
   assign rsp_dot_count     = rsp_dot_ff;
   assign rsp_outside_count = rsp_outside_ff;
   assign rsp_low_x         = rsp_low_x_ff;
   assign rsp_high_x        = rsp_high_x_ff;
   assign rsp_low_y         = rsp_low_y_ff;
   assign rsp_high_y        = rsp_high_y_ff;
   assign rsp_peak_radius   = rsp_peak_ff;

endmodule : bdsm_datapath

`default_nettype wire

@@ rtl/core/beam_dac_statistics_monitor.sv @@
// Top level of the beam DAC statistics monitor: controller plus datapath.
// Depends on bdsm_pkg, bdsm_ctrl and bdsm_datapath.
//
//   Channel   Direction  Handshake               Carries
//   req_      in         req_valid / req_ready   kind, blank_on, dac_x, dac_y
//   rsp_      out        rsp_valid / rsp_ready   counters, bounding box, peak radius
//   csr_      in         csr_wr_en (no wait)     rim_radius
//
// A lit DAC write squares x, then y, then runs the square root, which produces one
// result bit per cycle; every other item goes straight from capture to commit.
// One item is in work at a time.
// Reset is synchronous; it blanks the beam, clears the statistics and sets rim_radius
// to 2047. A stalled result holds the next item in its final state; the block
// still accepts that next item while the earlier result waits for its transfer.
`timescale 1ns / 1ps
`default_nettype none

module beam_dac_statistics_monitor #(
   parameter int DAC_BITS = bdsm_pkg::DAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [bdsm_pkg::KIND_BITS-1:0]        req_kind,
   input  wire logic                                  req_blank_on,
   input  wire logic [DAC_BITS-1:0]                   req_dac_x,
   input  wire logic [DAC_BITS-1:0]                   req_dac_y,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [bdsm_pkg::COUNT_BITS-1:0]            rsp_move_count,
   output logic [bdsm_pkg::COUNT_BITS-1:0]            rsp_dot_count,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_low_x,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_high_x,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_low_y,
   output logic signed [bdsm_pkg::COORD_OUT_BITS-1:0] rsp_high_y,
   output logic [bdsm_pkg::COORD_OUT_BITS-1:0]        rsp_peak_radius,
   output logic [bdsm_pkg::COUNT_BITS-1:0]            rsp_outside_count,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bdsm_pkg::RIM_BITS-1:0]         csr_wr_data
);
   import bdsm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer for capture, squaring, root steps and commit.
   bdsm_ctrl #(
      .DAC_BITS (DAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, statistics and result registers.
   bdsm_datapath #(
      .DAC_BITS (DAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_blank_on      (req_blank_on),
      .req_dac_x         (req_dac_x),
      .req_dac_y         (req_dac_y),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_move_count    (rsp_move_count),
      .rsp_dot_count     (rsp_dot_count),
      .rsp_low_x         (rsp_low_x),
      .rsp_high_x        (rsp_high_x),
      .rsp_low_y         (rsp_low_y),
      .rsp_high_y        (rsp_high_y),
      .rsp_peak_radius   (rsp_peak_radius),
      .rsp_outside_count (rsp_outside_count)
   );

endmodule : beam_dac_statistics_monitor

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the beam DAC statistics monitor.
// Depends on bdsm_pkg and beam_dac_statistics_monitor; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench;
   import bdsm_pkg::*;

   localparam int                 DAC_MID        = 1 << (DAC_BITS_DEFAULT - 1);
   localparam logic [KIND_BITS-1:0] KIND_UNUSED  = 2'd3;
   localparam int                 HOLD_CYCLES    = 250;
   localparam int                 WATCHDOG_LIMIT = 3000;
   localparam int                 RANDOM_PHASES  = 8;
   localparam int                 PHASE_ITEMS    = 230;

   // One result of the block, field for field.
   typedef struct packed {
      logic [COUNT_BITS-1:0]            move_count;
      logic [COUNT_BITS-1:0]            dot_count;
      logic signed [COORD_OUT_BITS-1:0] low_x;
      logic signed [COORD_OUT_BITS-1:0] high_x;
      logic signed [COORD_OUT_BITS-1:0] low_y;
      logic signed [COORD_OUT_BITS-1:0] high_y;
      logic [COORD_OUT_BITS-1:0]        peak_radius;
      logic [COUNT_BITS-1:0]            outside_count;
   } beam_stats_type;

   // Tracks the beam statistics and holds the results still owed by the block.
   class beam_stats_tracker_type;
      logic [RIM_BITS-1:0]       rim;
      logic                      blanked;
      logic [COUNT_BITS-1:0]     moves;
      logic [COUNT_BITS-1:0]     dots;
      logic [COUNT_BITS-1:0]     outside;
      logic [COORD_OUT_BITS-1:0] peak;
      int                        min_x, max_x, min_y, max_y;
      beam_stats_type            expected_stats[$];
      int                        mismatches;

      function new();
         rim = RIM_RESET;
         blanked = 1'b1;
         mismatches = 0;
         clear_stats();
      endfunction

      function void clear_stats();
         moves = '0;
         dots = '0;
         outside = '0;
         peak = '0;
         min_x = DAC_MID - 1;
         max_x = -DAC_MID;
         min_y = DAC_MID - 1;
         max_y = -DAC_MID;
      endfunction

      function void set_rim(logic [RIM_BITS-1:0] value);
         rim = value;
      endfunction

      function int pending();
         return expected_stats.size();
      endfunction

      // Counters stop at all ones.
      function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] value);
         return (value == '1) ? value : value + 1'b1;
      endfunction

      // Floor square root, settling one result bit per step from the top.
      function logic [COORD_OUT_BITS-1:0] floor_root(int unsigned square);
         int unsigned root, trial;
         root = 0;
         for (int b = COORD_OUT_BITS - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= square) root = trial;
         end
         return root[COORD_OUT_BITS-1:0];
      endfunction

      // Applies one accepted request and queues the statistics that follow it.
      function void note_request(logic [KIND_BITS-1:0] kind, logic blank_on,
                                 logic [DAC_BITS_DEFAULT-1:0] x,
                                 logic [DAC_BITS_DEFAULT-1:0] y);
         int                        cx, cy;
         int unsigned               r2;
         logic [COORD_OUT_BITS-1:0] r;
         beam_stats_type            want;
         case (kind)
            KIND_BLANK: blanked = blank_on;
            KIND_CLEAR: clear_stats();
            KIND_DAC: begin
               if (blanked) begin
                  moves = bump(moves);
               end else begin
                  cx = int'(x) - DAC_MID;
                  cy = int'(y) - DAC_MID;
                  r2 = cx * cx + cy * cy;
                  r = floor_root(r2);
                  dots = bump(dots);
                  if (cx < min_x) min_x = cx;
                  if (cx > max_x) max_x = cx;
                  if (cy < min_y) min_y = cy;
                  if (cy > max_y) max_y = cy;
                  if (r > peak) peak = r;
                  if (r > rim) outside = bump(outside);
               end
            end
            default: ;
         endcase
         want.move_count    = moves;
         want.dot_count     = dots;
         want.low_x         = min_x[COORD_OUT_BITS-1:0];
         want.high_x        = max_x[COORD_OUT_BITS-1:0];
         want.low_y         = min_y[COORD_OUT_BITS-1:0];
         want.high_y        = max_y[COORD_OUT_BITS-1:0];
         want.peak_radius   = peak;
         want.outside_count = outside;
         expected_stats = {expected_stats, want};
      endfunction

      // Prints one line per mismatch and counts it.
      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
         mismatches++;
      endtask

      // Compares one delivered result against the oldest expectation.
      task check_response(beam_stats_type got);
         beam_stats_type want;
         if (expected_stats.size() == 0) begin
            report_mismatch("result with nothing outstanding", 0, 0);
         end else begin
            want = expected_stats.pop_front();
            if (got.move_count !== want.move_count)
               report_mismatch("move_count", got.move_count, want.move_count);
            if (got.dot_count !== want.dot_count)
               report_mismatch("dot_count", got.dot_count, want.dot_count);
            if (got.low_x !== want.low_x)
               report_mismatch("low_x", 32'(got.low_x), 32'(want.low_x));
            if (got.high_x !== want.high_x)
               report_mismatch("high_x", 32'(got.high_x), 32'(want.high_x));
            if (got.low_y !== want.low_y)
               report_mismatch("low_y", 32'(got.low_y), 32'(want.low_y));
            if (got.high_y !== want.high_y)
               report_mismatch("high_y", 32'(got.high_y), 32'(want.high_y));
            if (got.peak_radius !== want.peak_radius)
               report_mismatch("peak_radius", 32'(got.peak_radius),
                               32'(want.peak_radius));
            if (got.outside_count !== want.outside_count)
               report_mismatch("outside_count", got.outside_count, want.outside_count);
         end
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [KIND_BITS-1:0]              req_kind = KIND_UNUSED;
   logic                              req_blank_on = 1'b0;
   logic [DAC_BITS_DEFAULT-1:0]       req_dac_x = '0;
   logic [DAC_BITS_DEFAULT-1:0]       req_dac_y = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]             rsp_move_count;
   logic [COUNT_BITS-1:0]             rsp_dot_count;
   logic signed [COORD_OUT_BITS-1:0]  rsp_low_x;
   logic signed [COORD_OUT_BITS-1:0]  rsp_high_x;
   logic signed [COORD_OUT_BITS-1:0]  rsp_low_y;
   logic signed [COORD_OUT_BITS-1:0]  rsp_high_y;
   logic [COORD_OUT_BITS-1:0]         rsp_peak_radius;
   logic [COUNT_BITS-1:0]             rsp_outside_count;
   logic                              csr_wr_en = 1'b0;
   logic [RIM_BITS-1:0]               csr_wr_data = '0;

   beam_stats_tracker_type            tracker;
   logic [RIM_BITS-1:0]               current_rim = RIM_RESET;
   bit                                steady_flow = 1'b0;
   bit                                hold_responses = 1'b0;
   int                                quiet_cycles = 0;

   beam_dac_statistics_monitor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_blank_on      (req_blank_on),
      .req_dac_x         (req_dac_x),
      .req_dac_y         (req_dac_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_move_count    (rsp_move_count),
      .rsp_dot_count     (rsp_dot_count),
      .rsp_low_x         (rsp_low_x),
      .rsp_high_x        (rsp_high_x),
      .rsp_low_y         (rsp_low_y),
      .rsp_high_y        (rsp_high_y),
      .rsp_peak_radius   (rsp_peak_radius),
      .rsp_outside_count (rsp_outside_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Observe both channels; a request transfer is noted before a result is checked.
   always @(posedge clock) begin : observe
      beam_stats_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_kind, req_blank_on, req_dac_x, req_dac_y);
         if (rsp_valid && rsp_ready) begin
            got.move_count    = rsp_move_count;
            got.dot_count     = rsp_dot_count;
            got.low_x         = rsp_low_x;
            got.high_x        = rsp_high_x;
            got.low_y         = rsp_low_y;
            got.high_y        = rsp_high_y;
            got.peak_radius   = rsp_peak_radius;
            got.outside_count = rsp_outside_count;
            tracker.check_response(got);
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: a random stall before each transfer, or one long hold-off on request.
   initial begin : response_side
      int stall;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 6);
         if (hold_responses) begin
            hold_responses = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offers one request after a random gap and returns at the edge of its transfer.
   task automatic offer_item(input logic [KIND_BITS-1:0] kind, input logic blank_on,
                             input logic [DAC_BITS_DEFAULT-1:0] x,
                             input logic [DAC_BITS_DEFAULT-1:0] y);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_blank_on <= blank_on;
      req_dac_x    <= x;
      req_dac_y    <= y;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits until every expected result has been delivered.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Rim radius writes happen only with the block idle.
   task automatic write_rim(input logic [RIM_BITS-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_rim(value);
      current_rim = value;
   endtask

   // Mostly lit DAC writes, with blanking, clears and the unused kind mixed in.
   task automatic random_item(output logic [KIND_BITS-1:0] kind, output logic blank_on,
                              output logic [DAC_BITS_DEFAULT-1:0] x,
                              output logic [DAC_BITS_DEFAULT-1:0] y);
      int pick, cx;
      pick = $urandom_range(0, 99);
      // Unblanking is favored so that most writes land as dots.
      blank_on = ($urandom_range(0, 2) == 0);
      x = DAC_BITS_DEFAULT'($urandom_range(0, 4095));
      y = DAC_BITS_DEFAULT'($urandom_range(0, 4095));
      if (pick < 65)      kind = KIND_DAC;
      else if (pick < 85) kind = KIND_BLANK;
      else if (pick < 93) kind = KIND_CLEAR;
      else                kind = KIND_UNUSED;
      if (kind == KIND_DAC) begin
         case ($urandom_range(0, 9))
            0: begin
               x = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
               y = $urandom_range(0, 1) ? 12'd2048 : 12'd4095;
            end
            1, 2, 3: begin
               x = DAC_BITS_DEFAULT'(DAC_MID + $urandom_range(0, 128) - 64);
               y = DAC_BITS_DEFAULT'(DAC_MID + $urandom_range(0, 128) - 64);
            end
            4: begin
               // Radius just below, at or just above the rim, on one axis.
               cx = int'(current_rim) + int'($urandom_range(0, 2)) - 1;
               if (cx > DAC_MID - 1) cx = DAC_MID - 1;
               if ($urandom_range(0, 1)) cx = -cx;
               x = DAC_BITS_DEFAULT'(cx + DAC_MID);
               y = DAC_BITS_DEFAULT'(DAC_MID);
               if ($urandom_range(0, 1)) {x, y} = {y, x};
            end
            default: ;
         endcase
      end
   endtask

   initial begin : stimulus
      logic [KIND_BITS-1:0]        kind;
      logic                        blank_on;
      logic [DAC_BITS_DEFAULT-1:0] x, y;
      logic [RIM_BITS-1:0]         rim;
      tracker = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset rim: empty box, moves, extremes, exact roots.
      offer_item(KIND_UNUSED, 1'b1, 12'd4095, 12'd4095);
      offer_item(KIND_DAC,    1'b0, 12'd0,    12'd0);
      offer_item(KIND_BLANK,  1'b0, 12'hABC,  12'h543);
      offer_item(KIND_DAC,    1'b1, 12'd0,    12'd0);
      offer_item(KIND_DAC,    1'b0, 12'd4095, 12'd4095);
      offer_item(KIND_DAC,    1'b0, 12'd2048, 12'd2048);
      offer_item(KIND_DAC,    1'b0, 12'd0,    12'd4095);
      offer_item(KIND_DAC,    1'b0, 12'd4095, 12'd0);
      offer_item(KIND_DAC,    1'b0, 12'd2051, 12'd2052);
      offer_item(KIND_DAC,    1'b0, 12'd2051, 12'd2051);
      offer_item(KIND_UNUSED, 1'b0, 12'd0,    12'd0);
      offer_item(KIND_CLEAR,  1'b1, 12'd4095, 12'd0);
      offer_item(KIND_DAC,    1'b0, 12'd4095, 12'd2048);
      offer_item(KIND_DAC,    1'b0, 12'd0,    12'd2048);
      offer_item(KIND_BLANK,  1'b1, 12'd0,    12'd0);
      offer_item(KIND_DAC,    1'b0, 12'd100,  12'd200);
      offer_item(KIND_CLEAR,  1'b0, 12'd0,    12'd0);
      offer_item(KIND_DAC,    1'b0, 12'd300,  12'd400);
      offer_item(KIND_BLANK,  1'b0, 12'd0,    12'd0);

      // Rim extremes and the exact boundary, where equal is still inside.
      write_rim(12'd0);
      offer_item(KIND_DAC, 1'b0, 12'd2048, 12'd2048);
      offer_item(KIND_DAC, 1'b0, 12'd2049, 12'd2048);
      write_rim(12'd4095);
      offer_item(KIND_DAC, 1'b0, 12'd0,    12'd0);
      write_rim(12'd100);
      offer_item(KIND_DAC, 1'b0, 12'd2148, 12'd2048);
      offer_item(KIND_DAC, 1'b0, 12'd2048, 12'd1947);

      // Random phases, each with its own rim setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       rim = 12'd0;
            1:       rim = 12'd4095;
            2:       rim = 12'd2896;
            3:       rim = 12'd64;
            4:       rim = 12'd2047;
            default: rim = RIM_BITS'($urandom_range(0, 4095));
         endcase
         write_rim(rim);
         steady_flow = (phase == 2);
         // The result side holds off so the block fills up and stalls requests.
         if (phase == 3 || phase == 6) hold_responses = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_item(kind, blank_on, x, y);
            offer_item(kind, blank_on, x, y);
         end
      end
      steady_flow = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report_mismatch("results never delivered", tracker.pending(), 0);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
